// ===== hdl/risc32_pkg.sv =====
// Shared types, constants and decode function for the 32-bit instruction executor.
package risc32_pkg;

  localparam int unsigned DATA_WORDS_DEF = 4096;
  localparam int unsigned PC_W = 16;
  localparam int unsigned PLEN_W = 17;
  localparam int unsigned STEP_W = 24;
  localparam int unsigned REG_AW = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 1'd1;

  localparam logic [STEP_W-1:0] STEP_LIMIT_RST = 24'd2000000;

  typedef logic [5:0] opcode_t;

  localparam opcode_t OP_ADD  = 6'h01;
  localparam opcode_t OP_SUB  = 6'h02;
  localparam opcode_t OP_AND  = 6'h03;
  localparam opcode_t OP_OR   = 6'h04;
  localparam opcode_t OP_XOR  = 6'h05;
  localparam opcode_t OP_SHL  = 6'h06;
  localparam opcode_t OP_SHR  = 6'h07;
  localparam opcode_t OP_SLT  = 6'h08;
  localparam opcode_t OP_MUL  = 6'h09;
  localparam opcode_t OP_ADDI = 6'h10;
  localparam opcode_t OP_LI   = 6'h11;
  localparam opcode_t OP_LW   = 6'h12;
  localparam opcode_t OP_SW   = 6'h13;
  localparam opcode_t OP_BEQ  = 6'h14;
  localparam opcode_t OP_BNE  = 6'h15;
  localparam opcode_t OP_JMP  = 6'h16;
  localparam opcode_t OP_JAL  = 6'h17;
  localparam opcode_t OP_JR   = 6'h18;
  localparam opcode_t OP_SYS  = 6'h1F;
  localparam opcode_t OP_HLT  = 6'h3F;

  localparam logic [1:0] PRINT_NONE = 2'd0;
  localparam logic [1:0] PRINT_CHAR = 2'd1;
  localparam logic [1:0] PRINT_INT  = 2'd2;

  localparam logic [31:0] SYS_HALT = 32'd0;
  localparam logic [31:0] SYS_PUTC = 32'd1;
  localparam logic [31:0] SYS_PUTI = 32'd2;

  localparam logic [REG_AW-1:0] REG_ZERO = 4'd0;
  localparam logic [REG_AW-1:0] REG_LINK = 4'd15;

  typedef struct packed {
    opcode_t           op;
    logic [REG_AW-1:0] rd;
    logic [REG_AW-1:0] rs;
    logic [REG_AW-1:0] rt;
    logic [31:0]       imm;
    logic [25:0]       target;
  } decode_t;

  typedef struct packed {
    logic              stop;
    logic [PC_W-1:0]   pc;
    logic [STEP_W-1:0] step;
    logic              wr_en;
    logic              ld_en;
    logic              st_en;
    logic [REG_AW-1:0] wr_rd;
    logic [31:0]       wr_data;
    logic [31:0]       mem_addr;
    logic [1:0]        print_kind;
    logic [31:0]       print_value;
  } ex_res_t;

  function automatic decode_t decode(input logic [31:0] w);
    decode_t d;
    d.op     = w[31:26];
    d.rd     = w[25:22];
    d.rs     = w[21:18];
    d.rt     = w[17:14];
    d.imm    = {{14{w[17]}}, w[17:0]};
    d.target = w[25:0];
    return d;
  endfunction

endpackage

// ===== hdl/risc32_regfile.sv =====
// Sixteen-entry register file in two banks with write-first registered reads.
module risc32_regfile (
  input  logic                          clk,
  input  logic                          we,
  input  logic [risc32_pkg::REG_AW-1:0] waddr,
  input  logic [31:0]                   wdata,
  input  logic                          ren,
  input  logic [risc32_pkg::REG_AW-1:0] raddr_s,
  input  logic [risc32_pkg::REG_AW-1:0] raddr_t,
  input  logic [risc32_pkg::REG_AW-1:0] raddr_d,
  output logic [31:0]                   rdata_s,
  output logic [31:0]                   rdata_t,
  output logic [31:0]                   rdata_d
);

  logic [31:0] bank_a [16];
  logic [31:0] bank_b [16];

  always_ff @(posedge clk) begin
    if (we) begin
      bank_a[waddr] <= wdata;
    end
    if (ren) begin
      rdata_s <= (we && waddr == raddr_s) ? wdata : bank_a[raddr_s];
      rdata_t <= (we && waddr == raddr_t) ? wdata : bank_a[raddr_t];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      bank_b[waddr] <= wdata;
    end
    if (ren) begin
      rdata_d <= (we && waddr == raddr_d) ? wdata : bank_b[raddr_d];
    end
  end

endmodule

// ===== hdl/risc32_dmem.sv =====
// Word-addressed data memory with one write port and one registered read port.
module risc32_dmem #(
  parameter int unsigned DATA_WORDS = risc32_pkg::DATA_WORDS_DEF,
  localparam int unsigned AW = $clog2(DATA_WORDS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DATA_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/risc32_execute.sv =====
// Decode and execute of one instruction against forwarded operands and machine state.
module risc32_execute #(
  parameter int unsigned DATA_WORDS = risc32_pkg::DATA_WORDS_DEF
) (
  input  logic [31:0]                   inst,
  input  logic [31:0]                   a,
  input  logic [31:0]                   b,
  input  logic [31:0]                   c,
  input  logic [risc32_pkg::PC_W-1:0]   pc,
  input  logic [risc32_pkg::STEP_W-1:0] step,
  input  logic                          stopped,
  input  logic [risc32_pkg::PLEN_W-1:0] plen,
  input  logic [risc32_pkg::STEP_W-1:0] slimit,
  output risc32_pkg::ex_res_t           res
);

  localparam logic [31:0] DW = 32'(DATA_WORDS);

  risc32_pkg::decode_t     d;
  logic                    pre_stop;
  logic                    halt;
  logic                    post_stop;
  logic [risc32_pkg::STEP_W-1:0] step_inc;
  logic [31:0]             link;
  logic [31:0]             nxt;
  logic [31:0]             addr;
  logic                    in_range;
  logic                    wr;
  logic [31:0]             wval;
  logic [1:0]              pkind;
  logic [31:0]             pval;

  always_comb begin
    d        = risc32_pkg::decode(inst);
    pre_stop = stopped || ({1'b0, pc} >= plen) || (step >= slimit);
    step_inc = step + 24'd1;
    link     = {15'd0, {1'b0, pc} + 17'd1};
    addr     = a + d.imm;
    in_range = addr < DW;
    nxt      = link;
    halt     = 1'b0;
    wr       = 1'b0;
    wval     = '0;
    pkind    = risc32_pkg::PRINT_NONE;
    pval     = '0;

    unique case (d.op)
      risc32_pkg::OP_ADD: begin
        wr = 1'b1; wval = a + b;
      end
      risc32_pkg::OP_SUB: begin
        wr = 1'b1; wval = a - b;
      end
      risc32_pkg::OP_AND: begin
        wr = 1'b1; wval = a & b;
      end
      risc32_pkg::OP_OR: begin
        wr = 1'b1; wval = a | b;
      end
      risc32_pkg::OP_XOR: begin
        wr = 1'b1; wval = a ^ b;
      end
      risc32_pkg::OP_SHL: begin
        wr = 1'b1; wval = a << b[4:0];
      end
      risc32_pkg::OP_SHR: begin
        wr = 1'b1; wval = a >> b[4:0];
      end
      risc32_pkg::OP_SLT: begin
        wr = 1'b1; wval = {31'd0, $signed(a) < $signed(b)};
      end
      risc32_pkg::OP_MUL: begin
        wr = 1'b1; wval = a * b;
      end
      risc32_pkg::OP_ADDI: begin
        wr = 1'b1; wval = addr;
      end
      risc32_pkg::OP_LI: begin
        wr = 1'b1; wval = d.imm;
      end
      risc32_pkg::OP_LW: begin
        wr = in_range;
      end
      risc32_pkg::OP_SW: begin
        wr = 1'b0;
      end
      risc32_pkg::OP_BEQ: begin
        if (c == a) nxt = link + d.imm;
      end
      risc32_pkg::OP_BNE: begin
        if (c != a) nxt = link + d.imm;
      end
      risc32_pkg::OP_JMP: begin
        nxt = {6'd0, d.target};
      end
      risc32_pkg::OP_JAL: begin
        wr = 1'b1; wval = link; nxt = {6'd0, d.target};
      end
      risc32_pkg::OP_JR: begin
        nxt = a;
      end
      risc32_pkg::OP_SYS: begin
        priority if (d.imm == risc32_pkg::SYS_PUTC) begin
          pkind = risc32_pkg::PRINT_CHAR; pval = {24'd0, a[7:0]};
        end else if (d.imm == risc32_pkg::SYS_PUTI) begin
          pkind = risc32_pkg::PRINT_INT; pval = a;
        end else if (d.imm == risc32_pkg::SYS_HALT) begin
          halt = 1'b1;
        end else begin
          halt = 1'b0;
        end
      end
      risc32_pkg::OP_HLT: begin
        halt = 1'b1;
      end
      default: begin
        wr = 1'b0;
      end
    endcase

    post_stop = halt || (nxt >= {15'd0, plen}) || (step_inc >= slimit);

    res.stop        = pre_stop || post_stop;
    res.pc          = (pre_stop || post_stop) ? pc : nxt[15:0];
    res.step        = pre_stop ? step : step_inc;
    res.wr_rd       = (d.op == risc32_pkg::OP_JAL) ? risc32_pkg::REG_LINK : d.rd;
    res.wr_en       = !pre_stop && wr && (res.wr_rd != risc32_pkg::REG_ZERO);
    res.wr_data     = wval;
    res.ld_en       = !pre_stop && (d.op == risc32_pkg::OP_LW) && in_range;
    res.st_en       = !pre_stop && (d.op == risc32_pkg::OP_SW) && in_range;
    res.mem_addr    = addr;
    res.print_kind  = pre_stop ? risc32_pkg::PRINT_NONE : pkind;
    res.print_value = pre_stop ? 32'd0 : pval;
  end

endmodule

// ===== hdl/risc32_instruction_execute.sv =====
// Top level of the 32-bit instruction executor: pipeline registers, forwarding and handshakes.
// An accepted item is registered in the execute stage, and its result in the output register.
// Throughput: one item per cycle unless the output stalls; a load writes back in the cycle
// after it executes and is forwarded from the data memory read register to the next item.
// Reset: synchronous, active low; afterwards a clearing pass over each data memory word zeroes
// the data memory and the register file, with in_ready low and configuration writes taken.
module risc32_instruction_execute #(
  parameter int unsigned DATA_WORDS = risc32_pkg::DATA_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [risc32_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [risc32_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [31:0]                       in_instruction,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [15:0]                       out_next_pc,
  output logic                              out_halted,
  output logic [1:0]                        out_print_kind,
  output logic signed [31:0]                out_print_value
);

  localparam int unsigned AW = $clog2(DATA_WORDS);
  localparam logic [AW-1:0] CLR_LAST = AW'(DATA_WORDS - 1);

  logic                              clearing_r;
  logic [AW-1:0]                     clr_cnt_r;
  logic [risc32_pkg::PLEN_W-1:0]     plen_r;
  logic [risc32_pkg::STEP_W-1:0]     slimit_r;

  logic                              ex_valid_r;
  logic [31:0]                       inst_r;
  logic [risc32_pkg::PC_W-1:0]       pc_r;
  logic [risc32_pkg::STEP_W-1:0]     step_r;
  logic                              stopped_r;

  logic                              wb_valid_r;
  logic                              wb_load_r;
  logic [risc32_pkg::REG_AW-1:0]     wb_rd_r;
  logic [31:0]                       wb_data_r;

  logic                              out_valid_r;
  logic [15:0]                       out_next_pc_r;
  logic                              out_halted_r;
  logic [1:0]                        out_print_kind_r;
  logic [31:0]                       out_print_value_r;

  logic                              accept;
  logic                              ex_fire;
  risc32_pkg::decode_t               dec_in;
  risc32_pkg::decode_t               dec_ex;
  logic [31:0]                       a_q, b_q, c_q;
  logic [31:0]                       a_fwd, b_fwd, c_fwd;
  logic [31:0]                       dmem_q;
  logic [31:0]                       wb_value;
  risc32_pkg::ex_res_t               res;

  logic                              rf_we;
  logic [risc32_pkg::REG_AW-1:0]     rf_waddr;
  logic [31:0]                       rf_wdata;
  logic                              dm_we;
  logic [AW-1:0]                     dm_waddr;
  logic [31:0]                       dm_wdata;
  logic                              dm_re;

  assign ex_fire  = ex_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clearing_r && (!ex_valid_r || ex_fire);
  assign accept   = in_valid && in_ready;

  assign dec_in   = risc32_pkg::decode(in_instruction);
  assign dec_ex   = risc32_pkg::decode(inst_r);
  assign wb_value = wb_load_r ? dmem_q : wb_data_r;

  assign a_fwd = (wb_valid_r && wb_rd_r == dec_ex.rs) ? wb_value : a_q;
  assign b_fwd = (wb_valid_r && wb_rd_r == dec_ex.rt) ? wb_value : b_q;
  assign c_fwd = (wb_valid_r && wb_rd_r == dec_ex.rd) ? wb_value : c_q;

  assign rf_we    = clearing_r || wb_valid_r;
  assign rf_waddr = clearing_r ? clr_cnt_r[risc32_pkg::REG_AW-1:0] : wb_rd_r;
  assign rf_wdata = clearing_r ? 32'd0 : wb_value;

  assign dm_we    = clearing_r || (ex_fire && res.st_en);
  assign dm_waddr = clearing_r ? clr_cnt_r : res.mem_addr[AW-1:0];
  assign dm_wdata = clearing_r ? 32'd0 : c_fwd;
  assign dm_re    = ex_fire && res.ld_en;

  risc32_regfile u_regfile (
    .clk     (clk),
    .we      (rf_we),
    .waddr   (rf_waddr),
    .wdata   (rf_wdata),
    .ren     (accept),
    .raddr_s (dec_in.rs),
    .raddr_t (dec_in.rt),
    .raddr_d (dec_in.rd),
    .rdata_s (a_q),
    .rdata_t (b_q),
    .rdata_d (c_q)
  );

  risc32_dmem #(
    .DATA_WORDS (DATA_WORDS)
  ) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (dm_re),
    .raddr (res.mem_addr[AW-1:0]),
    .rdata (dmem_q)
  );

  risc32_execute #(
    .DATA_WORDS (DATA_WORDS)
  ) u_execute (
    .inst    (inst_r),
    .a       (a_fwd),
    .b       (b_fwd),
    .c       (c_fwd),
    .pc      (pc_r),
    .step    (step_r),
    .stopped (stopped_r),
    .plen    (plen_r),
    .slimit  (slimit_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == CLR_LAST) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r   <= '0;
      slimit_r <= risc32_pkg::STEP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        risc32_pkg::CFG_PROGRAM_LENGTH: plen_r   <= cfg_wdata[risc32_pkg::PLEN_W-1:0];
        risc32_pkg::CFG_STEP_LIMIT:     slimit_r <= cfg_wdata;
        default:                        plen_r   <= plen_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r <= 1'b0;
      pc_r       <= '0;
      step_r     <= '0;
      stopped_r  <= 1'b0;
    end else begin
      if (accept) begin
        ex_valid_r <= 1'b1;
      end else if (ex_fire) begin
        ex_valid_r <= 1'b0;
      end
      if (ex_fire) begin
        pc_r      <= res.pc;
        step_r    <= res.step;
        stopped_r <= res.stop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inst_r <= in_instruction;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else if (ex_fire) begin
      wb_valid_r <= res.wr_en;
    end else if (!ex_valid_r) begin
      wb_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      wb_load_r <= res.ld_en;
      wb_rd_r   <= res.wr_rd;
      wb_data_r <= res.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ex_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      out_next_pc_r     <= res.stop ? 16'd0 : res.pc;
      out_halted_r      <= res.stop;
      out_print_kind_r  <= res.print_kind;
      out_print_value_r <= res.print_value;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_next_pc_r;
  assign out_halted      = out_halted_r;
  assign out_print_kind  = out_print_kind_r;
  assign out_print_value = $signed(out_print_value_r);

endmodule

// ===== hdl/risc32_checker.sv =====
// Port-level checker for the instruction executor and its bind to the top level.
module risc32_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [15:0]        out_next_pc,
  input logic               out_halted,
  input logic [1:0]         out_print_kind,
  input logic signed [31:0] out_print_value
);

  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("Input accepted right after reset.");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |=> ##1 out_valid)
    else $error("No result two cycles after an item was accepted.");

  a_halted_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_halted) |-> (out_next_pc == 16'd0))
    else $error("Halted result carries a nonzero next pc.");

  a_no_print_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_print_kind == risc32_pkg::PRINT_NONE) |-> (out_print_value == 32'sd0))
    else $error("Print value set without a print event.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_next_pc) && $stable(out_halted)
      && $stable(out_print_kind) && $stable(out_print_value)))
    else $error("Stalled result changed or dropped.");

endmodule

bind risc32_instruction_execute risc32_checker u_risc32_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the instruction executor with a shadow machine that predicts results.
module testbench;

  localparam int unsigned DMEM_WORDS = risc32_pkg::DATA_WORDS_DEF;
  localparam int HALF_PERIOD = 6;
  localparam int TIMEOUT_CYCLES = 300000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 128;
  localparam int unsigned MAX_PROGRAM = 65536;

  localparam risc32_pkg::opcode_t OP_RESERVED = 6'h2A;

  typedef struct {
    logic [15:0] next_pc;
    logic        halted;
    logic [1:0]  print_kind;
    logic [31:0] print_value;
  } exec_result_t;

  typedef enum int {
    STOP_HLT,
    STOP_SYS,
    STOP_JUMP,
    STOP_STEP_COUNT,
    STOP_STEP_LIMIT_LOW,
    STOP_EMPTY_PROGRAM
  } stop_kind_t;

  class core_shadow_t;
    logic [31:0] regs [16];
    logic [31:0] dmem [DMEM_WORDS];
    logic [31:0] pc;
    logic [31:0] steps;
    logic [31:0] prog_len;
    logic [31:0] step_lim;
    bit stopped;
    exec_result_t expected_results [$];
    int errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc = '0;
      steps = '0;
      prog_len = '0;
      step_lim = {8'h00, risc32_pkg::STEP_LIMIT_RST};
      stopped = 1'b0;
      errors = 0;
    endfunction

    function void set_register(logic [risc32_pkg::CFG_IDX_W-1:0] idx,
                               logic [risc32_pkg::CFG_DATA_W-1:0] v);
      if (idx == risc32_pkg::CFG_PROGRAM_LENGTH) begin
        prog_len = {15'h0, v[risc32_pkg::PLEN_W-1:0]};
      end else begin
        step_lim = {8'h00, v};
      end
    endfunction

    function logic [31:0] imm_of(logic [31:0] w);
      return {{14{w[17]}}, w[17:0]};
    endfunction

    function void put_reg(logic [3:0] idx, logic [31:0] v);
      if (idx != risc32_pkg::REG_ZERO) regs[idx] = v;
    endfunction

    // Pc after the instruction, ignoring the range check.
    function logic [31:0] dest_of(logic [31:0] w);
      risc32_pkg::opcode_t op = w[31:26];
      logic [31:0] a = regs[w[21:18]];
      logic [31:0] d = regs[w[25:22]];
      logic [31:0] imm = imm_of(w);
      case (op)
        risc32_pkg::OP_BEQ: return (d == a) ? pc + 1 + imm : pc + 1;
        risc32_pkg::OP_BNE: return (d != a) ? pc + 1 + imm : pc + 1;
        risc32_pkg::OP_JMP, risc32_pkg::OP_JAL: return {6'h00, w[25:0]};
        risc32_pkg::OP_JR: return a;
        default: return pc + 1;
      endcase
    endfunction

    function bit stops_on(logic [31:0] w);
      risc32_pkg::opcode_t op = w[31:26];
      return stopped || pc >= prog_len || steps + 1 >= step_lim ||
             op == risc32_pkg::OP_HLT ||
             (op == risc32_pkg::OP_SYS && imm_of(w) == risc32_pkg::SYS_HALT) ||
             dest_of(w) >= prog_len;
    endfunction

    function void note_instruction(logic [31:0] w);
      exec_result_t r;
      risc32_pkg::opcode_t op;
      logic [3:0] rd;
      logic [31:0] a, b, imm, nxt, addr;
      r.print_kind = risc32_pkg::PRINT_NONE;
      r.print_value = '0;
      if (!stopped && (pc >= prog_len || steps >= step_lim)) stopped = 1'b1;
      if (!stopped) begin
        op = w[31:26];
        rd = w[25:22];
        a = regs[w[21:18]];
        b = regs[w[17:14]];
        imm = imm_of(w);
        nxt = dest_of(w);
        addr = a + imm;
        steps = steps + 1;
        case (op)
          risc32_pkg::OP_ADD: put_reg(rd, a + b);
          risc32_pkg::OP_SUB: put_reg(rd, a - b);
          risc32_pkg::OP_AND: put_reg(rd, a & b);
          risc32_pkg::OP_OR: put_reg(rd, a | b);
          risc32_pkg::OP_XOR: put_reg(rd, a ^ b);
          risc32_pkg::OP_SHL: put_reg(rd, a << b[4:0]);
          risc32_pkg::OP_SHR: put_reg(rd, a >> b[4:0]);
          risc32_pkg::OP_SLT: put_reg(rd, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
          risc32_pkg::OP_MUL: put_reg(rd, a * b);
          risc32_pkg::OP_ADDI: put_reg(rd, a + imm);
          risc32_pkg::OP_LI: put_reg(rd, imm);
          risc32_pkg::OP_LW: begin
            if (addr < DMEM_WORDS) put_reg(rd, dmem[addr]);
          end
          risc32_pkg::OP_SW: begin
            if (addr < DMEM_WORDS) dmem[addr] = regs[rd];
          end
          risc32_pkg::OP_JAL: put_reg(risc32_pkg::REG_LINK, pc + 1);
          risc32_pkg::OP_SYS: begin
            if (imm == risc32_pkg::SYS_PUTC) begin
              r.print_kind = risc32_pkg::PRINT_CHAR;
              r.print_value = {24'h0, a[7:0]};
            end else if (imm == risc32_pkg::SYS_PUTI) begin
              r.print_kind = risc32_pkg::PRINT_INT;
              r.print_value = a;
            end else if (imm == risc32_pkg::SYS_HALT) begin
              stopped = 1'b1;
            end
          end
          risc32_pkg::OP_HLT: stopped = 1'b1;
          default: ;
        endcase
        if (!stopped) begin
          if (nxt >= prog_len || steps >= step_lim) begin
            stopped = 1'b1;
          end else begin
            pc = {16'h0, nxt[15:0]};
          end
        end
      end
      r.halted = stopped;
      r.next_pc = stopped ? 16'd0 : pc[15:0];
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [15:0] npc, logic h, logic [1:0] pk, logic [31:0] pv);
      exec_result_t e;
      if (expected_results.size() == 0) begin
        $error("unexpected result: next_pc %0d halted %0d", npc, h);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (npc !== e.next_pc) begin
        $error("next_pc: expected %0d, actual %0d", e.next_pc, npc);
        errors++;
      end
      if (h !== e.halted) begin
        $error("halted: expected %0d, actual %0d", e.halted, h);
        errors++;
      end
      if (pk !== e.print_kind) begin
        $error("print_kind: expected %0d, actual %0d", e.print_kind, pk);
        errors++;
      end
      if (pv !== e.print_value) begin
        $error("print_value: expected %0h, actual %0h", e.print_value, pv);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [risc32_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [risc32_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [31:0] in_instruction;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_next_pc;
  logic out_halted;
  logic [1:0] out_print_kind;
  logic signed [31:0] out_print_value;

  int send_idle_pct = 0;
  int stall_pct = 0;
  core_shadow_t tracker = new();

  risc32_instruction_execute dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_instruction(in_instruction),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_next_pc(out_next_pc),
    .out_halted(out_halted),
    .out_print_kind(out_print_kind),
    .out_print_value(out_print_value)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_result(out_next_pc, out_halted, out_print_kind, out_print_value);
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [31:0] rtype(risc32_pkg::opcode_t op, logic [3:0] rd,
                                        logic [3:0] rs, logic [3:0] rt);
    return {op, rd, rs, rt, 14'h0};
  endfunction

  function automatic logic [31:0] itype(risc32_pkg::opcode_t op, logic [3:0] rd,
                                        logic [3:0] rs, logic [17:0] imm);
    return {op, rd, rs, imm};
  endfunction

  function automatic logic [31:0] jtype(risc32_pkg::opcode_t op, logic [25:0] target);
    return {op, target};
  endfunction

  function automatic logic [17:0] small_imm();
    return 18'($urandom_range(40)) - 18'd20;
  endfunction

  function automatic logic [31:0] draft_instruction();
    int unsigned pick = $urandom_range(99);
    logic [3:0] rd = 4'($urandom);
    logic [3:0] rs = 4'($urandom);
    logic [3:0] rt = 4'($urandom);
    logic [17:0] imm = 18'($urandom);
    logic [31:0] w = $urandom;
    logic [17:0] mem_imm;
    logic [3:0] mem_base;
    case ($urandom_range(3))
      0: mem_imm = 18'($urandom_range(63));
      1: mem_imm = 18'(DMEM_WORDS - 1);
      2: mem_imm = 18'(DMEM_WORDS);
      default: mem_imm = imm;
    endcase
    mem_base = $urandom_range(1) ? risc32_pkg::REG_ZERO : rs;
    if (pick < 12) begin
      return itype(risc32_pkg::OP_LI, rd, rs,
                   $urandom_range(1) ? 18'($urandom_range(63)) : imm);
    end
    if (pick < 20) begin
      return itype(risc32_pkg::OP_ADDI, rd, rs, $urandom_range(1) ? small_imm() : imm);
    end
    if (pick < 42) begin
      return {risc32_pkg::opcode_t'($urandom_range(risc32_pkg::OP_MUL, risc32_pkg::OP_ADD)),
              rd, rs, rt, w[13:0]};
    end
    if (pick < 52) return itype(risc32_pkg::OP_SW, rd, mem_base, mem_imm);
    if (pick < 62) return itype(risc32_pkg::OP_LW, rd, mem_base, mem_imm);
    if (pick < 72) begin
      return itype($urandom_range(1) ? risc32_pkg::OP_BEQ : risc32_pkg::OP_BNE, rd, rs,
                   $urandom_range(3) != 0 ? small_imm() : imm);
    end
    if (pick < 78) begin
      return jtype($urandom_range(1) ? risc32_pkg::OP_JMP : risc32_pkg::OP_JAL,
                   26'($urandom_range(tracker.prog_len - 1)));
    end
    if (pick < 84) begin
      return {risc32_pkg::OP_JR, rd, $urandom_range(1) ? risc32_pkg::REG_LINK : rs,
              w[17:0]};
    end
    if (pick < 90) begin
      return itype(risc32_pkg::OP_SYS, rd, rs, $urandom_range(3) == 0 ? imm :
                   ($urandom_range(1) ? 18'(risc32_pkg::SYS_PUTC) :
                                        18'(risc32_pkg::SYS_PUTI)));
    end
    if (pick < 95) return {6'($urandom), w[25:0]};
    return w;
  endfunction

  // Random instruction, preferring one that keeps the machine running.
  function automatic logic [31:0] next_instruction();
    logic [31:0] w;
    for (int k = 0; k < 16; k++) begin
      w = draft_instruction();
      if (!tracker.stops_on(w)) return w;
    end
    return jtype(risc32_pkg::OP_JMP, 26'($urandom_range(tracker.prog_len - 1)));
  endfunction

  task automatic send(logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_instruction = w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_instruction(w);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (tracker.expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(logic [risc32_pkg::CFG_IDX_W-1:0] idx,
                                logic [risc32_pkg::CFG_DATA_W-1:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_register(idx, v);
  endtask

  task automatic reconfigure();
    int unsigned len_v;
    case ($urandom_range(2))
      0: len_v = MAX_PROGRAM;
      1: len_v = $urandom_range(MAX_PROGRAM, tracker.pc + 1);
      default: begin
        len_v = tracker.pc + 2 + $urandom_range(300);
        if (len_v > MAX_PROGRAM) len_v = MAX_PROGRAM;
      end
    endcase
    write_register(risc32_pkg::CFG_PROGRAM_LENGTH, risc32_pkg::CFG_DATA_W'(len_v));
    write_register(risc32_pkg::CFG_STEP_LIMIT,
                   $urandom_range(1) ? {risc32_pkg::CFG_DATA_W{1'b1}} :
                   risc32_pkg::CFG_DATA_W'(tracker.steps + 2000 + $urandom_range(1000000)));
  endtask

  task automatic run_directed();
    send(itype(risc32_pkg::OP_LI, 4'd1, risc32_pkg::REG_ZERO, 18'h1FFFF));
    send(itype(risc32_pkg::OP_LI, 4'd2, risc32_pkg::REG_ZERO, 18'h20000));
    send(rtype(risc32_pkg::OP_ADD, 4'd3, 4'd1, 4'd2));
    send(rtype(risc32_pkg::OP_SUB, 4'd4, 4'd2, 4'd1));
    send(rtype(risc32_pkg::OP_AND, 4'd5, 4'd1, 4'd2));
    send(rtype(risc32_pkg::OP_OR, 4'd6, 4'd1, 4'd2));
    send(rtype(risc32_pkg::OP_XOR, 4'd7, 4'd1, 4'd2));
    send(itype(risc32_pkg::OP_LI, 4'd8, risc32_pkg::REG_ZERO, 18'd37));
    send(rtype(risc32_pkg::OP_SHL, 4'd9, 4'd1, 4'd8));
    send(rtype(risc32_pkg::OP_SHR, 4'd10, 4'd2, 4'd8));
    send(rtype(risc32_pkg::OP_SLT, 4'd11, 4'd2, 4'd1));
    send(rtype(risc32_pkg::OP_SLT, 4'd12, 4'd1, 4'd2));
    send(rtype(risc32_pkg::OP_MUL, 4'd13, 4'd2, 4'd2));
    send(itype(risc32_pkg::OP_ADDI, risc32_pkg::REG_ZERO, 4'd1, 18'd5));
    send(itype(risc32_pkg::OP_SW, 4'd1, risc32_pkg::REG_ZERO, 18'(DMEM_WORDS - 1)));
    send(itype(risc32_pkg::OP_LW, 4'd14, risc32_pkg::REG_ZERO, 18'(DMEM_WORDS - 1)));
    send(itype(risc32_pkg::OP_SW, 4'd2, risc32_pkg::REG_ZERO, 18'(DMEM_WORDS)));
    send(itype(risc32_pkg::OP_LW, 4'd14, risc32_pkg::REG_ZERO, 18'h3FFFF));
    send(itype(risc32_pkg::OP_BEQ, risc32_pkg::REG_ZERO, risc32_pkg::REG_ZERO, 18'd3));
    send(itype(risc32_pkg::OP_BNE, 4'd1, risc32_pkg::REG_ZERO, 18'h3FFFE));
    send(jtype(risc32_pkg::OP_JAL, 26'd65535));
    send(rtype(risc32_pkg::OP_JR, risc32_pkg::REG_ZERO, risc32_pkg::REG_LINK,
               risc32_pkg::REG_ZERO));
    send(itype(risc32_pkg::OP_SYS, risc32_pkg::REG_ZERO, 4'd1, 18'(risc32_pkg::SYS_PUTC)));
    send(itype(risc32_pkg::OP_SYS, risc32_pkg::REG_ZERO, 4'd2, 18'(risc32_pkg::SYS_PUTI)));
    send(itype(risc32_pkg::OP_SYS, risc32_pkg::REG_ZERO, 4'd1, 18'd3));
    send(jtype(OP_RESERVED, 26'h3FFFFFF));
  endtask

  task automatic run_stop(stop_kind_t kind);
    case (kind)
      STOP_HLT: send(jtype(risc32_pkg::OP_HLT, 26'($urandom)));
      STOP_SYS: begin
        send(itype(risc32_pkg::OP_SYS, 4'($urandom), 4'($urandom),
                   18'(risc32_pkg::SYS_HALT)));
      end
      STOP_JUMP: send(jtype(risc32_pkg::OP_JMP, 26'h3FFFFFF));
      STOP_STEP_COUNT: begin
        write_register(risc32_pkg::CFG_STEP_LIMIT,
                       risc32_pkg::CFG_DATA_W'(tracker.steps + 3));
        repeat (3) send(itype(risc32_pkg::OP_LI, 4'd1, risc32_pkg::REG_ZERO, 18'($urandom)));
      end
      STOP_STEP_LIMIT_LOW: begin
        write_register(risc32_pkg::CFG_STEP_LIMIT, risc32_pkg::CFG_DATA_W'(1));
        send(next_instruction());
      end
      default: begin
        write_register(risc32_pkg::CFG_PROGRAM_LENGTH, '0);
        send(next_instruction());
      end
    endcase
    repeat (4) send($urandom);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_instruction = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    write_register(risc32_pkg::CFG_PROGRAM_LENGTH, risc32_pkg::CFG_DATA_W'(MAX_PROGRAM));
    write_register(risc32_pkg::CFG_STEP_LIMIT, {risc32_pkg::CFG_DATA_W{1'b1}});
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      drain();
      reconfigure();
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 72;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 72;
        end
        default: begin
          send_idle_pct = 9;
          stall_pct = 9;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send(next_instruction());
    end
    drain();
    run_stop(stop_kind_t'($urandom_range(5)));
    drain();
    repeat (8) @(negedge clk);
    if (tracker.errors == 0 && tracker.expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
